// File: rtl/core/aes_pkg.sv
package aes_pkg;

    typedef struct packed {
        logic        mode;
        logic [63:0] block_high;
        logic [63:0] block_low;
    } in_beat_t;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } out_beat_t;

    localparam logic [2:0] REG_KEY_LEN = 3'd0;
    localparam logic [2:0] REG_KEY_0   = 3'd1;
    localparam logic [2:0] REG_KEY_1   = 3'd2;
    localparam logic [2:0] REG_KEY_2   = 3'd3;
    localparam logic [2:0] REG_KEY_3   = 3'd4;

    localparam logic [1:0] KLEN_128 = 2'd0;
    localparam logic [1:0] KLEN_192 = 2'd1;
    localparam logic [1:0] KLEN_256 = 2'd2;

    localparam int QUEUE_DEPTH = 2;

    function automatic logic [7:0] xtime(input logic [7:0] x);
        xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] aa;
        acc = 8'h00;
        aa  = a;
        for (int k = 0; k < 8; k++)
        begin
            if (b[k])
                acc = acc ^ aa;
            aa = xtime(aa);
        end
        gmul = acc;
    endfunction

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] SBOX_REV [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

endpackage

// File: rtl/core/aes_block_cipher_unit.sv
// AES block cipher (128/192/256-bit keys). Blocks enter through a two-beat queue and go one
// at a time through a single round unit that does one round per cycle; each result then moves
// to the output register. After any key or length register write, the first following block
// waits for the key schedule, which writes one 32-bit word per cycle (44, 52 or 60 words).
module aes_block_cipher_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  aes_pkg::in_beat_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output aes_pkg::out_beat_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data
);

    logic [1:0]   klen_reg;
    logic [255:0] key_reg;
    logic         expanded_reg;
    logic         expanded_next;
    logic         start;
    logic         kx_busy;
    logic         rk_wr_en;
    logic [5:0]   rk_wr_word;
    logic [31:0]  rk_wr_data;
    logic         q_valid;
    logic         q_pop;
    logic [3:0]   nr;
    logic         cfg_hit;
    aes_pkg::in_beat_t q_data;

    assign cfg_ready = 1'b1;
    assign cfg_hit   = cfg_valid && (cfg_index <= aes_pkg::REG_KEY_3);
    assign nr = (klen_reg == aes_pkg::KLEN_128) ? 4'd10 :
                (klen_reg == aes_pkg::KLEN_192) ? 4'd12 : 4'd14;

    // Expand lazily: start the schedule once a block is waiting and keys are stale.
    assign start = q_valid && !expanded_reg && !kx_busy;

    always_comb
    begin
        expanded_next = expanded_reg;
        if (start)
            expanded_next = 1'b1;
        if (cfg_hit)
            expanded_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            klen_reg     <= 2'd0;
            key_reg      <= 256'h0;
            expanded_reg <= 1'b0;
        end
        else
        begin
            expanded_reg <= expanded_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    aes_pkg::REG_KEY_LEN: klen_reg           <= cfg_data[1:0];
                    aes_pkg::REG_KEY_0:   key_reg[255:192] <= cfg_data;
                    aes_pkg::REG_KEY_1:   key_reg[191:128] <= cfg_data;
                    aes_pkg::REG_KEY_2:   key_reg[127:64]  <= cfg_data;
                    aes_pkg::REG_KEY_3:   key_reg[63:0]    <= cfg_data;
                    default:              ;
                endcase
            end
        end
    end

    aes_in_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_data   (q_data)
    );

    aes_key_expand u_kx (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .key_len (klen_reg),
        .key     (key_reg),
        .busy    (kx_busy),
        .wr_en   (rk_wr_en),
        .wr_word (rk_wr_word),
        .wr_data (rk_wr_data)
    );

    aes_round_engine u_eng (
        .clk        (clk),
        .rst_n      (rst_n),
        .nr         (nr),
        .enable     (expanded_reg && !kx_busy && !start),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_data     (q_data),
        .rk_wr_en   (rk_wr_en),
        .rk_wr_word (rk_wr_word),
        .rk_wr_data (rk_wr_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

`ifndef ASSERT_OFF
    a_no_pop_expand: assert property (@(posedge clk) disable iff (!rst_n)
        kx_busy |-> !q_pop)
        else $error("block taken during key expansion");
    a_start_stale: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> (kx_busy || !expanded_reg))
        else $error("key schedule did not run");
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_stall) |-> q_valid)
        else $error("input stalled with empty queue");
`endif

endmodule

// File: rtl/core/aes_in_queue.sv
module aes_in_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  aes_pkg::in_beat_t in_data,
    output logic              q_valid,
    input  logic              q_pop,
    output aes_pkg::in_beat_t q_data
);

    aes_pkg::in_beat_t slot_reg [aes_pkg::QUEUE_DEPTH];
    logic              rd_ptr_reg;
    logic              rd_ptr_next;
    logic              wr_ptr_reg;
    logic              wr_ptr_next;
    logic [1:0]        count_reg;
    logic [1:0]        count_next;
    logic              push;
    logic              pop;

    assign in_stall = (count_reg == 2'(aes_pkg::QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_pop && q_valid;
    assign q_data   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg ^ pop;
        wr_ptr_next = wr_ptr_reg ^ push;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= in_data;
    end

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(aes_pkg::QUEUE_DEPTH))
        else $error("queue count overflow");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd1) |-> (rd_ptr_reg != wr_ptr_reg))
        else $error("queue pointers disagree with count");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0) |=> (count_reg <= 2'd1))
        else $error("queue drained below empty");
`endif

endmodule

// File: rtl/core/aes_key_expand.sv
module aes_key_expand (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [1:0]   key_len,
    input  logic [255:0] key,
    output logic         busy,
    output logic         wr_en,
    output logic [5:0]   wr_word,
    output logic [31:0]  wr_data
);

    logic [255:0] win_reg;
    logic [255:0] win_next;
    logic [5:0]   idx_reg;
    logic [5:0]   idx_next;
    logic [3:0]   pos_reg;
    logic [3:0]   pos_next;
    logic [7:0]   rc_reg;
    logic [7:0]   rc_next;
    logic         busy_reg;
    logic         busy_next;
    logic [3:0]   nk;
    logic [5:0]   total;
    logic [31:0]  prev;
    logic [31:0]  back;
    logic [31:0]  t;
    logic [31:0]  w;

    // Window holds the last nk words, newest at the low end.
    always_comb
    begin
        nk    = (key_len == aes_pkg::KLEN_128) ? 4'd4 :
                (key_len == aes_pkg::KLEN_192) ? 4'd6 : 4'd8;
        total = (key_len == aes_pkg::KLEN_128) ? 6'd44 :
                (key_len == aes_pkg::KLEN_192) ? 6'd52 : 6'd60;
        prev  = win_reg[31:0];
        back  = win_reg[32*7 +: 32];
        if (nk == 4'd4)
            back = win_reg[32*3 +: 32];
        else if (nk == 4'd6)
            back = win_reg[32*5 +: 32];
        if (pos_reg == 4'd0)
            t = aes_pkg::sub_word({prev[23:0], prev[31:24]}) ^ {rc_reg, 24'h0};
        else if (nk == 4'd8 && pos_reg == 4'd4)
            t = aes_pkg::sub_word(prev);
        else
            t = prev;
        w = back ^ t;

        win_next  = win_reg;
        idx_next  = idx_reg;
        pos_next  = pos_reg;
        rc_next   = rc_reg;
        busy_next = busy_reg;
        wr_en     = 1'b0;
        wr_word   = idx_reg;
        wr_data   = w;
        if (start)
        begin
            busy_next = 1'b1;
            idx_next  = 6'd0;
            rc_next   = 8'h01;
            pos_next  = 4'd0;
            win_next  = key;
        end
        else if (busy_reg)
        begin
            wr_en = 1'b1;
            if (idx_reg < 6'(nk))
            begin
                // Load key words: shift out of the top of the window.
                wr_data  = win_reg[255 -: 32];
                win_next = {win_reg[223:0], 32'h0};
                if (idx_reg == 6'(nk) - 6'd1)
                begin
                    // Reload the key words, last key word at the low end.
                    if (nk == 4'd4)
                        win_next = {128'h0, key[255:128]};
                    else if (nk == 4'd6)
                        win_next = {64'h0, key[255:64]};
                    else
                        win_next = key;
                end
            end
            else
            begin
                win_next = {win_reg[223:0], w};
                if (pos_reg == 4'd0)
                    rc_next = aes_pkg::xtime(rc_reg);
                pos_next = (pos_reg == nk - 4'd1) ? 4'd0 : pos_reg + 4'd1;
            end
            idx_next = idx_reg + 6'd1;
            if (idx_reg == total - 6'd1)
                busy_next = 1'b0;
        end
    end

    assign busy = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 6'd0;
            pos_reg  <= 4'd0;
            rc_reg   <= 8'h01;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            pos_reg  <= pos_next;
            rc_reg   <= rc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

`ifndef ASSERT_OFF
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (idx_reg < 6'd60))
        else $error("key schedule ran past its end");
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (pos_reg < 4'd8))
        else $error("key schedule position out of range");
    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> busy_reg)
        else $error("round-key write while idle");
`endif

endmodule

// File: rtl/core/aes_round_engine.sv
module aes_round_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [3:0]         nr,
    input  logic               enable,
    input  logic               q_valid,
    output logic               q_pop,
    input  aes_pkg::in_beat_t  q_data,
    input  logic               rk_wr_en,
    input  logic [5:0]         rk_wr_word,
    input  logic [31:0]        rk_wr_data,
    output logic               out_valid,
    input  logic               out_stall,
    output aes_pkg::out_beat_t out_data
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ROUND = 3'b010,
        ST_DONE  = 3'b100
    } eng_state_t;

    logic [127:0] rk_mem [15];
    logic [127:0] rk_reg;

    eng_state_t   state_reg;
    eng_state_t   state_next;
    logic [127:0] st_reg;
    logic [127:0] st_next;
    logic [3:0]   rnd_reg;
    logic [3:0]   rnd_next;
    logic         dec_reg;
    logic         dec_next;
    logic         ov_reg;
    logic         ov_next;
    logic [127:0] res_reg;
    logic [127:0] res_next;

    // Round keys: one 128-bit key per entry, filled a word at a time, read whole.
    logic [3:0] rd_round_next;

    always_ff @(posedge clk)
    begin
        if (rk_wr_en)
            rk_mem[rk_wr_word[5:2]][127 - 32*rk_wr_word[1:0] -: 32] <= rk_wr_data;
    end

    always_ff @(posedge clk)
    begin
        rk_reg <= rk_mem[rd_round_next];
    end

    function automatic logic [127:0] fwd_round(input logic [127:0] s, input logic last);
        logic [7:0]   b [16];
        logic [7:0]   t [16];
        logic [127:0] o;
        for (int i = 0; i < 16; i++)
            b[i] = aes_pkg::SBOX[s[127 - 8*i -: 8]];
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[r + 4*c] = b[r + 4*((c + r) % 4)];
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
            begin
                if (last)
                    o[127 - 8*(r + 4*c) -: 8] = t[r + 4*c];
                else
                    o[127 - 8*(r + 4*c) -: 8] =
                        aes_pkg::xtime(t[r + 4*c]) ^
                        aes_pkg::xtime(t[(r+1)%4 + 4*c]) ^ t[(r+1)%4 + 4*c] ^
                        t[(r+2)%4 + 4*c] ^ t[(r+3)%4 + 4*c];
            end
        fwd_round = o;
    endfunction

    function automatic logic [127:0] inv_mix(input logic [127:0] s);
        logic [7:0]   a [16];
        logic [127:0] o;
        for (int i = 0; i < 16; i++)
            a[i] = s[127 - 8*i -: 8];
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                o[127 - 8*(r + 4*c) -: 8] =
                    aes_pkg::gmul(a[r + 4*c], 8'd14) ^
                    aes_pkg::gmul(a[(r+1)%4 + 4*c], 8'd11) ^
                    aes_pkg::gmul(a[(r+2)%4 + 4*c], 8'd13) ^
                    aes_pkg::gmul(a[(r+3)%4 + 4*c], 8'd9);
        inv_mix = o;
    endfunction

    function automatic logic [127:0] inv_sub_shift(input logic [127:0] s);
        logic [7:0]   b [16];
        logic [127:0] o;
        for (int i = 0; i < 16; i++)
            b[i] = s[127 - 8*i -: 8];
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                o[127 - 8*(r + 4*c) -: 8] = aes_pkg::SBOX_REV[b[r + 4*((c + 4 - r) % 4)]];
        inv_sub_shift = o;
    endfunction

    // st_reg holds the state before the key of round rnd_reg is added.
    always_comb
    begin
        state_next    = state_reg;
        st_next       = st_reg;
        rnd_next      = rnd_reg;
        dec_next      = dec_reg;
        ov_next       = ov_reg;
        res_next      = res_reg;
        q_pop         = 1'b0;
        rd_round_next = rnd_reg;

        if (ov_reg && !out_stall)
            ov_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                rd_round_next = 4'd0;
                if (enable && q_valid)
                begin
                    q_pop         = 1'b1;
                    dec_next      = q_data.mode;
                    st_next       = {q_data.block_high, q_data.block_low};
                    rnd_next      = q_data.mode ? nr : 4'd0;
                    rd_round_next = q_data.mode ? nr : 4'd0;
                    state_next    = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (!dec_reg)
                begin
                    // rk_reg holds key rnd_reg; add it, then run round rnd_reg+1.
                    if (rnd_reg == nr)
                    begin
                        st_next    = st_reg ^ rk_reg;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        st_next       = fwd_round(st_reg ^ rk_reg, (rnd_reg + 4'd1) == nr);
                        rnd_next      = rnd_reg + 4'd1;
                        rd_round_next = rnd_reg + 4'd1;
                    end
                end
                else
                begin
                    if (rnd_reg == 4'd0)
                    begin
                        st_next    = st_reg ^ rk_reg;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        if (rnd_reg == nr)
                            st_next = inv_sub_shift(st_reg ^ rk_reg);
                        else
                            st_next = inv_sub_shift(inv_mix(st_reg ^ rk_reg));
                        rnd_next      = rnd_reg - 4'd1;
                        rd_round_next = rnd_reg - 4'd1;
                    end
                end
            end
            ST_DONE:
            begin
                if (!ov_next)
                begin
                    res_next   = st_reg;
                    ov_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = ov_reg;
    assign out_data  = {res_reg[127:64], res_reg[63:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rnd_reg   <= 4'd0;
            dec_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            dec_reg   <= dec_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg  <= st_next;
        res_reg <= res_next;
    end

`ifndef ASSERT_OFF
    a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> (rnd_reg <= nr))
        else $error("round counter past last round");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == ST_IDLE && enable))
        else $error("queue popped while engine busy");
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && out_stall) |=> (ov_reg && $stable(res_reg)))
        else $error("stalled result changed");
`endif

endmodule
